[rtl/pre_pkg.sv]
// shared types, constants and helpers for the printable run extractor
// no dependencies

package pre_pkg;

    localparam int BUF_BYTES_DEF  = 512;
    localparam int HOLD_DEPTH_DEF = 64;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int MINLEN_W = 7;
    localparam int POS_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EOI  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EOR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 1'd1;

    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = 7'd4;

    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7e;
    localparam logic [BYTE_W-1:0] CH_0200  = 8'h80;

    typedef struct packed {
        logic accept;
        logic rel_read;
        logic rel_put;
    } t_pre_cmd;

    typedef struct packed {
        logic rel_start;
        logic rel_done;
        logic out_free;
    } t_pre_sts;

    function automatic logic is_printable(input logic [BYTE_W-1:0] b);
        return ((b >= CH_SPACE) && (b <= CH_TILDE)) || (b == CH_0200) || (b == CH_FF);
    endfunction

endpackage

[rtl/printable_run_extractor_unit.sv]
// Takes one item per accepted input: a data byte (tuser 0), end of input (tuser 1, the open
// run is flushed) or end of region (tuser 2, the open run is dropped). Runs of printable bytes
// of at least min_length characters come out one character per item with the file position
// of the run's first byte; the final character carries tlast. An item that gives at most one
// result is taken while the output register can be loaded. When a run reaches min_length,
// its earlier held bytes leave in a burst: each is read from the hold memory, then put into
// the output register once it is free; no input is taken during the burst. Configuration
// writes are always taken; writing base_offset also reloads the position counter.
// depends on pre_pkg, pre_ctrl, pre_datapath, pre_ram

module printable_run_extractor_unit #(
    parameter int BUF_BYTES  = pre_pkg::BUF_BYTES_DEF,
    parameter int HOLD_DEPTH = pre_pkg::HOLD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // data_byte
    input  logic [pre_pkg::FUNC_W-1:0]    s_axis_tuser,   // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,   // char_out, run_offset
    output logic                          m_axis_tlast,   // last
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    import pre_pkg::*;

    t_pre_cmd cmd;
    t_pre_sts sts;

    assign o_cfg_ready = 1'b1;

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pre_datapath #(
        .BUF_BYTES  (BUF_BYTES),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (s_axis_tuser),
        .i_data_byte  (s_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_m_tready   (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_char_out   (m_axis_tdata[7:0]),
        .o_run_offset (m_axis_tdata[39:8]),
        .o_last       (m_axis_tlast)
    );

endmodule

[rtl/pre_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pre_ctrl.sv]
// controller: input acceptance and burst release sequencing
// depends on pre_pkg

module pre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  pre_pkg::t_pre_sts i_sts,
    output pre_pkg::t_pre_cmd o_cmd
);

    import pre_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_s_tready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.rel_read  = 1'b0;
        o_cmd.rel_put   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready   = i_sts.out_free;
                o_cmd.accept = i_s_tvalid && i_sts.out_free;
                if (o_cmd.accept && i_sts.rel_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rel_read = 1'b1;
                n_state        = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.rel_put = 1'b1;
                    n_state       = i_sts.rel_done ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_put_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rel_read |=> (r_state == S_PUT))
        else $error("release put does not follow read");

endmodule

[rtl/pre_datapath.sv]
// datapath: run state, hold buffer, position counter and output register
// depends on pre_pkg and pre_ram

module pre_datapath #(
    parameter int BUF_BYTES  = pre_pkg::BUF_BYTES_DEF,
    parameter int HOLD_DEPTH = pre_pkg::HOLD_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pre_pkg::t_pre_cmd                 i_cmd,
    output pre_pkg::t_pre_sts                 o_sts,
    input  logic [pre_pkg::FUNC_W-1:0]        i_func,
    input  logic [pre_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_cfg_valid,
    input  logic [pre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pre_pkg::POS_W-1:0]         i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_out_valid,
    output logic [pre_pkg::BYTE_W-1:0]        o_char_out,
    output logic [pre_pkg::POS_W-1:0]         o_run_offset,
    output logic                              o_last
);

    import pre_pkg::*;

    localparam int SCW  = $clog2(BUF_BYTES);
    localparam int HAW  = $clog2(HOLD_DEPTH);
    localparam int CMPW = ((SCW > MINLEN_W) ? SCW : MINLEN_W) + 1;
    localparam logic [SCW-1:0]      RUN_CAP = SCW'(BUF_BYTES - 2);
    localparam logic [MINLEN_W-1:0] HOLD_M  = MINLEN_W'(HOLD_DEPTH);
    localparam logic [CMPW-1:0]     HOLD_S  = CMPW'(HOLD_DEPTH);

    logic [MINLEN_W-1:0] r_min_length;
    logic [POS_W-1:0]    r_byte_pos;
    logic [POS_W-1:0]    r_run_start;
    logic [SCW-1:0]      r_count;
    logic [BYTE_W-1:0]   r_held_char;
    logic                r_held_valid;
    logic [HAW-1:0]      r_rel_idx;
    logic [HAW-1:0]      r_rel_end;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_char;
    logic [POS_W-1:0]    r_out_offset;
    logic                r_out_last;

    logic [MINLEN_W-1:0] eff_min;
    logic [SCW-1:0]      count_inc;
    logic                is_data;
    logic                printable;
    logic                below_cap;
    logic                qualifies;
    logic                flush;
    logic                discard;
    logic                take_byte;
    logic                hold_wr;
    logic [BYTE_W-1:0]   rd_data;

    always_comb begin
        eff_min = r_min_length;
        if (r_min_length == '0) begin
            eff_min = MINLEN_W'(1);
        end else if (r_min_length > HOLD_M) begin
            eff_min = HOLD_M;
        end
    end

    assign count_inc = r_count + SCW'(1);
    assign is_data   = (i_func == FUNC_DATA);
    assign printable = is_printable(i_data_byte);
    assign below_cap = (r_count < RUN_CAP);
    assign qualifies = (CMPW'(count_inc) >= CMPW'(eff_min));
    assign take_byte = i_cmd.accept && is_data && printable && below_cap;
    assign flush     = i_cmd.accept && ((is_data && !printable) || (i_func == FUNC_EOI));
    assign discard   = i_cmd.accept && (i_func == FUNC_EOR);
    assign hold_wr   = take_byte && !r_held_valid && !qualifies && (CMPW'(r_count) < HOLD_S);

    assign o_sts.rel_start = is_data && printable && below_cap && !r_held_valid && qualifies
                             && (r_count != '0);
    assign o_sts.rel_done  = ((HAW+1)'(r_rel_idx) + (HAW+1)'(1)) == (HAW+1)'(r_rel_end);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    pre_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HOLD_DEPTH)
    ) u_hold (
        .i_clk     (i_clk),
        .i_wr_en   (hold_wr),
        .i_wr_addr (HAW'(r_count)),
        .i_wr_data (i_data_byte),
        .i_rd_en   (i_cmd.rel_read),
        .i_rd_addr (r_rel_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RST;
            r_byte_pos   <= '0;
            r_count      <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_MIN_LENGTH)) begin
                r_min_length <= i_cfg_data[MINLEN_W-1:0];
            end
            if (i_cfg_valid && (i_cfg_index == CFG_BASE_OFFSET)) begin
                r_byte_pos <= i_cfg_data;
            end else if (i_cmd.accept && is_data) begin
                r_byte_pos <= r_byte_pos + POS_W'(1);
            end

            if (flush || discard) begin
                r_count      <= '0;
                r_held_valid <= 1'b0;
            end else if (take_byte) begin
                r_count <= count_inc;
                if (!r_held_valid && qualifies) begin
                    r_held_valid <= 1'b1;
                end
            end

            if ((flush && r_held_valid) || (take_byte && r_held_valid) || i_cmd.rel_put) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            if (r_count == '0) begin
                r_run_start <= r_byte_pos;
            end
            if (r_held_valid || qualifies) begin
                r_held_char <= i_data_byte;
            end
            if (!r_held_valid && qualifies) begin
                r_rel_idx <= '0;
                r_rel_end <= HAW'(r_count);
            end
        end
        if (i_cmd.rel_put) begin
            r_rel_idx <= r_rel_idx + HAW'(1);
        end

        if (i_cmd.rel_put) begin
            r_out_char   <= rd_data;
            r_out_offset <= r_run_start;
            r_out_last   <= 1'b0;
        end else if ((flush || take_byte) && r_held_valid) begin
            r_out_char   <= r_held_char;
            r_out_offset <= r_run_start;
            r_out_last   <= flush;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_out   = r_out_char;
    assign o_run_offset = r_out_offset;
    assign o_last       = r_out_last;

    a_put_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rel_put |-> o_sts.out_free)
        else $error("release put while output register busy");

    a_held_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_count != '0))
        else $error("pending character without an open run");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rel_read |-> (r_rel_idx < r_rel_end))
        else $error("hold buffer read beyond released span");

endmodule
